// ----- hw/rtl/assert_macros.svh -----
// Assertion shorthands, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every edge.
`define ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent on one edge implies consequent on the next.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pstb_pkg.sv -----
`timescale 1ns / 1ps

package pstb_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SLOT_W = 4;
	localparam logic [15:0] RUNS_FOREVER = 16'hFFFF;

	// controller -> datapath commands
	typedef struct packed {
		logic load;     // write one slot from the load fields
		logic capture;  // latch elapsed time for a tick
		logic issue;    // read slot at idx into the pipeline
		logic flush;    // emit the held word as last
	} pstb_cmd_t;

endpackage

// ----- hw/rtl/pstb_ctrl.sv -----
`timescale 1ns / 1ps

module pstb_ctrl #(
	parameter int SLOTS = pstb_pkg::SLOTS_DEF,
	parameter int IW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              mode,
	output logic              busy,
	output pstb_pkg::pstb_cmd_t cmd,
	output logic [IW-1:0]     idx
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DR1   = 3'd2;
	localparam logic [2:0] ST_DR2   = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [IW-1:0] cnt_q;
	logic          idle;

	assign idle = (state_q == ST_IDLE);
	assign busy = !idle;
	assign idx  = cnt_q;

	always_comb begin
		cmd.load    = idle && start && mode;
		cmd.capture = idle && start && !mode;
		cmd.issue   = (state_q == ST_SCAN);
		cmd.flush   = (state_q == ST_FLUSH);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !mode)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == LAST_IDX)
					state_d = ST_DR1;
			end
			ST_DR1:   state_d = ST_DR2;
			ST_DR2:   state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture)
				cnt_q <= '0;
			else if (cmd.issue)
				cnt_q <= cnt_q + IW'(1);
		end
	end

endmodule

// ----- hw/rtl/pstb_datapath.sv -----
`timescale 1ns / 1ps

module pstb_datapath #(
	parameter int SLOTS = pstb_pkg::SLOTS_DEF,
	parameter int IW = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pstb_pkg::pstb_cmd_t       cmd,
	input  logic [IW-1:0]             idx,
	input  logic [15:0]               elapsed_ms,
	input  logic [pstb_pkg::SLOT_W-1:0] slot,
	input  logic [30:0]               load_period,
	input  logic [30:0]               load_delay,
	input  logic [15:0]               load_runs,
	input  logic                      load_has_action,
	output logic                      strobe,
	output logic [pstb_pkg::SLOT_W-1:0] fired_slot,
	output logic                      last
);

	logic [30:0] period_mem [SLOTS];
	logic [31:0] rem_mem    [SLOTS];
	logic [15:0] runs_mem   [SLOTS];

	logic [SLOTS-1:0] runs_vld_q;
	logic [SLOTS-1:0] pend_q;
	logic [SLOTS-1:0] act_q;
	logic [15:0]      elapsed_q;

	// stage 1: registered memory reads
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic [30:0]   per_s1;
	logic [31:0]   rem_s1;
	logic [15:0]   runs_raw_s1;
	logic          vld_s1;

	// stage 2: saturated difference
	logic          valid_s2;
	logic [IW-1:0] idx_s2;
	logic [30:0]   per_s2;
	logic [31:0]   r_s2;
	logic [15:0]   runs_s2;
	logic          active_s2;

	logic          held_vld_q;
	logic [IW-1:0] held_idx_q;
	logic          strobe_q;
	logic          last_q;
	logic [pstb_pkg::SLOT_W-1:0] fired_q;

	logic          load_ok;
	logic [IW-1:0] load_idx;
	logic [15:0]   runs_s1;
	logic [32:0]   diff_s1;
	logic [31:0]   r_s1;
	logic          expire;
	logic [31:0]   new_rem;
	logic          pend_new;
	logic          fire;
	logic          dec;
	logic          rem_we;
	logic [IW-1:0] rem_addr;
	logic [31:0]   rem_wdata;
	logic          runs_we;
	logic [IW-1:0] runs_addr;
	logic [15:0]   runs_wdata;

	assign load_ok  = cmd.load && (int'(slot) < SLOTS);
	assign load_idx = IW'(slot);

	// stage 1 math: remaining minus elapsed, clamp at the most negative value
	assign runs_s1 = vld_s1 ? runs_raw_s1 : 16'd0;
	assign diff_s1 = {rem_s1[31], rem_s1} - {17'd0, elapsed_q};
	assign r_s1    = (diff_s1[32] && !diff_s1[31]) ? 32'h8000_0000 : diff_s1[31:0];

	// stage 2: reload on expiry, fire and count down
	assign expire   = valid_s2 && active_s2 && (r_s2[31] || (r_s2 == 32'd0));
	assign new_rem  = expire ? (r_s2 + {1'b0, per_s2}) : r_s2;
	assign pend_new = pend_q[idx_s2] || expire;
	assign fire     = valid_s2 && pend_new && act_q[idx_s2];
	assign dec      = fire && (runs_s2 != pstb_pkg::RUNS_FOREVER) && (runs_s2 != 16'd0);

	assign rem_we    = load_ok || (valid_s2 && active_s2);
	assign rem_addr  = load_ok ? load_idx : idx_s2;
	assign rem_wdata = load_ok ? {1'b0, load_delay} : new_rem;
	assign runs_we   = load_ok || dec;
	assign runs_addr = load_ok ? load_idx : idx_s2;
	assign runs_wdata = load_ok ? load_runs : (runs_s2 - 16'd1);

	always_ff @(posedge clk) begin
		if (load_ok)
			period_mem[load_idx] <= load_period;
		if (rem_we)
			rem_mem[rem_addr] <= rem_wdata;
		if (runs_we)
			runs_mem[runs_addr] <= runs_wdata;
		if (cmd.issue) begin
			per_s1      <= period_mem[idx];
			rem_s1      <= rem_mem[idx];
			runs_raw_s1 <= runs_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			elapsed_q <= elapsed_ms;
		idx_s1    <= idx;
		vld_s1    <= runs_vld_q[idx];
		idx_s2    <= idx_s1;
		per_s2    <= per_s1;
		r_s2      <= r_s1;
		runs_s2   <= runs_s1;
		active_s2 <= (runs_s1 != 16'd0);
		if (fire)
			held_idx_q <= idx_s2;
		fired_q <= pstb_pkg::SLOT_W'(held_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_vld_q <= '0;
			pend_q     <= '0;
			act_q      <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			held_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			if (load_ok) begin
				runs_vld_q[load_idx] <= 1'b1;
				act_q[load_idx]      <= load_has_action;
				pend_q[load_idx]     <= 1'b0;
			end else if (valid_s2) begin
				pend_q[idx_s2] <= pend_new && !fire;
			end
			// one word held back so the final one can carry last
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			if (fire) begin
				held_vld_q <= 1'b1;
				strobe_q   <= held_vld_q;
			end else if (cmd.flush) begin
				held_vld_q <= 1'b0;
				strobe_q   <= held_vld_q;
				last_q     <= held_vld_q;
			end
		end
	end

	assign strobe     = strobe_q;
	assign last       = last_q;
	assign fired_slot = fired_q;

endmodule

// ----- hw/rtl/periodic_software_timer_bank.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake                     | Words
// ---------+-------------------------------+---------------------------------------
// command  | start && !busy                | mode, elapsed_ms, slot, load_period,
//          |                               | load_delay, load_runs, load_has_action
// result   | strobe, one cycle per word    | fired_slot, last
//
// A load is done in the accept cycle; busy stays low.
// After accept, a tick holds busy through a scan of one slot per cycle through the
// slot memories' single read port, two pipeline stages, then a flush of the held word.
// Fired words leave in the cycle after the following fired slot is found, the last word
// in the cycle after the flush. Asynchronous active-low reset clears all slots to inactive.
// The receiver cannot stall; every word is on the result ports for exactly one cycle.

module periodic_software_timer_bank #(
	parameter int SLOTS = pstb_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [15:0] elapsed_ms,
	input  logic [3:0]  slot,
	input  logic [30:0] load_period,
	input  logic [30:0] load_delay,
	input  logic [15:0] load_runs,
	input  logic        load_has_action,
	output logic        strobe,
	output logic [3:0]  fired_slot,
	output logic        last
);

	`include "assert_macros.svh"

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	pstb_pkg::pstb_cmd_t cmd;
	logic [IW-1:0]       idx;

	pstb_ctrl #(
		.SLOTS(SLOTS),
		.IW(IW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.busy(busy),
		.cmd(cmd),
		.idx(idx)
	);

	pstb_datapath #(
		.SLOTS(SLOTS),
		.IW(IW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.idx(idx),
		.elapsed_ms(elapsed_ms),
		.slot(slot),
		.load_period(load_period),
		.load_delay(load_delay),
		.load_runs(load_runs),
		.load_has_action(load_has_action),
		.strobe(strobe),
		.fired_slot(fired_slot),
		.last(last)
	);

	`ASSERT_ALWAYS(a_last_has_strobe, !last || strobe, "last without strobe")
	`ASSERT_ALWAYS(a_strobe_from_tick, !strobe || $past(busy), "word outside a tick")
	`ASSERT_NEXT(a_tick_goes_busy, start && !busy && !mode, busy, "tick not started")
	`ASSERT_NEXT(a_load_stays_idle, start && !busy && mode, !busy, "load held busy")

endmodule

// ----- bench/timer_fire_checker.sv -----
`timescale 1ns / 1ps

package timer_bench_pkg;

	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_LOAD = 1'b1
	} cmd_mode_e;

endpackage

module timer_fire_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        mode,
	input  logic [15:0] elapsed_ms,
	input  logic [3:0]  slot,
	input  logic [30:0] load_period,
	input  logic [30:0] load_delay,
	input  logic [15:0] load_runs,
	input  logic        load_has_action,
	input  logic        strobe,
	input  logic [3:0]  fired_slot,
	input  logic        last,
	output int          mismatch_count,
	output int          words_due
);

	import pstb_pkg::*;
	import timer_bench_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam longint REMAIN_FLOOR = -64'sd2147483648;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              last;
	} fire_word_t;

	logic [30:0]        period_ms [NSLOT];
	logic signed [31:0] remain_ms [NSLOT];
	logic [15:0]        runs_left [NSLOT];
	logic               pending   [NSLOT];
	logic               armed     [NSLOT];

	fire_word_t fire_q[$];
	fire_word_t got_word;
	int errs;

	task automatic note_mismatch(input string field, input int want, input int got);
		errs++;
		if (errs <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// one tick: age every live slot, then queue the fired words in slot order
	task automatic advance_clock(input logic [15:0] dt);
		longint r;
		int hits[$];
		fire_word_t w;
		for (int i = 0; i < NSLOT; i++) begin
			if (runs_left[i] != 16'd0) begin
				r = longint'(remain_ms[i]) - longint'(dt);
				if (r < REMAIN_FLOOR)
					r = REMAIN_FLOOR;
				if (r <= 0) begin
					r = r + longint'(period_ms[i]);
					pending[i] = 1'b1;
				end
				remain_ms[i] = r[31:0];
			end
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (armed[i] && pending[i]) begin
				pending[i] = 1'b0;
				if (runs_left[i] != RUNS_FOREVER && runs_left[i] != 16'd0)
					runs_left[i] = runs_left[i] - 16'd1;
				hits.push_back(i);
			end
		end
		foreach (hits[j]) begin
			w.slot = SLOT_W'(hits[j]);
			w.last = (j == hits.size() - 1);
			fire_q.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				period_ms[i] = '0;
				remain_ms[i] = '0;
				runs_left[i] = '0;
				pending[i]   = 1'b0;
				armed[i]     = 1'b0;
			end
			fire_q.delete();
			errs = 0;
			mismatch_count <= 0;
			words_due <= 0;
		end else begin
			if (strobe) begin
				if (fire_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: word for slot %0d (last %0d) with nothing expected",
							$time, fired_slot, last);
				end else begin
					got_word = fire_q.pop_front();
					if (fired_slot !== got_word.slot)
						note_mismatch("fired_slot", got_word.slot, fired_slot);
					if (last !== got_word.last)
						note_mismatch("last", got_word.last, last);
				end
			end
			if (start && !busy) begin
				if (mode == MODE_LOAD) begin
					if (slot < NSLOT) begin
						period_ms[slot] = load_period;
						remain_ms[slot] = {1'b0, load_delay};
						runs_left[slot] = load_runs;
						armed[slot]     = load_has_action;
						pending[slot]   = 1'b0;
					end
				end else begin
					advance_clock(elapsed_ms);
				end
			end
			mismatch_count <= errs;
			words_due <= fire_q.size();
		end
	end

endmodule

// ----- bench/periodic_software_timer_bank_test.sv -----
`timescale 1ns / 1ps

module periodic_software_timer_bank_test;

	import pstb_pkg::*;
	import timer_bench_pkg::*;

	localparam int RUN_LIMIT = 200_000;
	localparam int DRAIN_CYCLES = SLOTS_DEF + 8;
	localparam int ITEM_GOAL = 280;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [15:0] elapsed_ms;
	logic [3:0]  slot;
	logic [30:0] load_period;
	logic [30:0] load_delay;
	logic [15:0] load_runs;
	logic        load_has_action;
	logic        strobe;
	logic [3:0]  fired_slot;
	logic        last;
	int          mismatch_count;
	int          words_due;

	int cycles = 0;
	int items;
	bit no_gaps;

	periodic_software_timer_bank uut (.*);
	timer_fire_checker fire_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [15:0] pick_runs();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 16'($urandom_range(1, 4));
		if (r < 6)
			return RUNS_FOREVER;
		if (r == 6)
			return 16'd0;
		return 16'($urandom_range(1, 40));
	endfunction

	// optional idle gap first, then hold the word until the block takes it
	task automatic send(input cmd_mode_e m, input logic [15:0] dt, input logic [3:0] s,
			input logic [30:0] p, input logic [30:0] d, input logic [15:0] n,
			input logic act);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		mode            <= m;
		elapsed_ms      <= dt;
		slot            <= s;
		load_period     <= p;
		load_delay      <= d;
		load_runs       <= n;
		load_has_action <= act;
		@(posedge clk);
		while (busy) @(posedge clk);
		items++;
	endtask

	task automatic tick(input logic [15:0] dt);
		send(MODE_TICK, dt, 4'($urandom), 31'($urandom), 31'($urandom), 16'($urandom),
			1'($urandom));
	endtask

	task automatic load(input logic [3:0] s, input logic [30:0] p, input logic [30:0] d,
			input logic [15:0] n, input logic act);
		send(MODE_LOAD, 16'($urandom), s, p, d, n, act);
	endtask

	initial begin
		int pick;
		items = 0;
		no_gaps = 1'b0;
		arst_n          <= 1'b0;
		start           <= 1'b0;
		mode            <= MODE_TICK;
		elapsed_ms      <= '0;
		slot            <= '0;
		load_period     <= '0;
		load_delay      <= '0;
		load_runs       <= '0;
		load_has_action <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tick(16'd0);
		load(4'd0, 31'd10, 31'd0, 16'd2, 1'b1);
		tick(16'd0);                                       // zero remaining fires at once
		load(4'd15, 31'h7FFF_FFFF, 31'h7FFF_FFFF, RUNS_FOREVER, 1'b1);
		load(4'd7, 31'd5, 31'd3, 16'd1, 1'b0);             // fires silently, stays pending
		load(4'd3, 31'd1, 31'd1, RUNS_FOREVER, 1'b1);
		load(4'd4, 31'd0, 31'd0, 16'd0, 1'b1);             // inactive
		tick(16'hFFFF);
		tick(16'd1);
		load(4'd7, 31'd100, 31'd100, 16'd2, 1'b1);         // reload drops the pending mark
		tick(16'd0);
		load(4'd3, 31'd0, 31'd0, 16'd0, 1'b0);
		load(4'd10, 31'h2AAA_AAAA, 31'h5555_5555, 16'hAAAA, 1'b1);
		load(4'd11, 31'h5555_5555, 31'h2AAA_AAAA, 16'h5555, 1'b1);
		tick(16'hAAAA);
		tick(16'h5555);
		tick(16'd0);

		while (items < ITEM_GOAL) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				repeat ($urandom_range(1, 6))
					load(4'($urandom_range(0, 15)), 31'($urandom_range(0, 50)),
						31'($urandom_range(0, 60)), pick_runs(),
						$urandom_range(0, 9) != 0);
				repeat ($urandom_range(1, 6))
					tick(16'($urandom_range(0, 80)));
			end else if (pick == 7) begin
				// every slot fires on the same tick
				for (int s = 0; s < SLOTS_DEF; s++)
					load(4'(s), 31'($urandom_range(0, 20)), 31'($urandom_range(0, 20)),
						($urandom_range(0, 3) == 0) ? RUNS_FOREVER : 16'($urandom_range(1, 3)),
						1'b1);
				tick(16'd20);
				repeat (2) tick(16'($urandom_range(0, 30)));
			end else if ($urandom_range(0, 1) == 0) begin
				load(4'($urandom), 31'($urandom), 31'($urandom), 16'($urandom), 1'($urandom));
			end else begin
				tick(16'($urandom));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (busy || words_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && words_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
